### rtl/apcht_pkg.sv
package apcht_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int AXIS_W          = 2;
    localparam int APEX_W          = 32;
    localparam int APER_W          = 24;
    localparam int COS_W           = 17;
    localparam int TOL_W           = 31;

    localparam logic [COS_W-1:0] COS_RESET = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS     = 3'd0,
        REG_APEX_X   = 3'd1,
        REG_APEX_Y   = 3'd2,
        REG_APEX_Z   = 3'd3,
        REG_APERTURE = 3'd4,
        REG_COS      = 3'd5,
        REG_TOL      = 3'd6
    } reg_idx_t;

    typedef enum logic [AXIS_W-1:0] {
        AXIS_Z = 2'd0,
        AXIS_X = 2'd1,
        AXIS_Y = 2'd2
    } axis_t;

    typedef struct packed {
        logic       op;
        logic [1:0] rng;
    } flag_t;

endpackage

### rtl/apcht_dly.sv
module apcht_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

### rtl/apcht_mul.sv
module apcht_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic               clk,
    input  logic               en,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] p
);

    localparam int NA  = (A_W + 31) / 32;
    localparam int NB  = (B_W + 31) / 32;
    localparam int FW  = (NA + NB) * 32;
    localparam int P_W = A_W + B_W;

    logic [NA*32-1:0] a_pad;
    logic [NB*32-1:0] b_pad;
    logic [63:0]      pp_reg [NA*NB];
    logic [FW-1:0]    sum;
    logic [P_W-1:0]   p_reg;

    assign a_pad = (NA*32)'(a);
    assign b_pad = (NB*32)'(b);

    // partial products, 32 by 32
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i*NB+j] <= a_pad[i*32 +: 32] * b_pad[j*32 +: 32];
                end
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                sum = sum + (FW'(pp_reg[i*NB+j]) << (32 * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= sum[P_W-1:0];
        end
    end

    assign p = p_reg;

endmodule

### rtl/apcht_prep.sv
module apcht_prep #(
    parameter int COORD_WIDTH = 32,
    parameter int MW          = 33
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [1:0]             axis,
    input  logic [COORD_WIDTH-1:0] apex_x,
    input  logic [COORD_WIDTH-1:0] apex_y,
    input  logic [COORD_WIDTH-1:0] apex_z,
    input  logic [30:0]            tol,
    input  logic                   opcode,
    input  logic [COORD_WIDTH-1:0] coord_x,
    input  logic [COORD_WIDTH-1:0] coord_y,
    input  logic [COORD_WIDTH-1:0] coord_z,
    input  logic [COORD_WIDTH-1:0] upper_x,
    input  logic [COORD_WIDTH-1:0] upper_y,
    input  logic [COORD_WIDTH-1:0] upper_z,
    output logic [MW-1:0]          mlo0,
    output logic [MW-1:0]          mlo1,
    output logic [MW-1:0]          mhi0,
    output logic [MW-1:0]          mhi1,
    output logic [MW-1:0]          zlo,
    output logic [MW-1:0]          zhi,
    output apcht_pkg::flag_t       flags
);

    import apcht_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int CW = MW + 1;

    logic [W-1:0]         lo_w [3];
    logic [W-1:0]         hi_w [3];
    logic [W-1:0]         ap_w [3];
    logic signed [CW-1:0] lo_s [3];
    logic signed [CW-1:0] hi_s [3];
    logic signed [CW-1:0] ap_s [3];
    logic signed [CW-1:0] sel_lo [3];
    logic signed [CW-1:0] sel_hi [3];
    logic signed [CW-1:0] t_s;
    logic [MW-1:0]        mag_lo [3];
    logic [MW-1:0]        mag_hi [3];
    logic [1:0]           rng;

    logic [MW-1:0] mlo0_reg, mlo1_reg, mhi0_reg, mhi1_reg, zlo_reg, zhi_reg;
    flag_t         flags_reg;

    // cross axes first, cone axis last
    always_comb
    begin
        case (axis)
            AXIS_X:
            begin
                lo_w[0] = coord_y; lo_w[1] = coord_z; lo_w[2] = coord_x;
                hi_w[0] = upper_y; hi_w[1] = upper_z; hi_w[2] = upper_x;
            end
            AXIS_Y:
            begin
                lo_w[0] = coord_z; lo_w[1] = coord_x; lo_w[2] = coord_y;
                hi_w[0] = upper_z; hi_w[1] = upper_x; hi_w[2] = upper_y;
            end
            default:
            begin
                lo_w[0] = coord_x; lo_w[1] = coord_y; lo_w[2] = coord_z;
                hi_w[0] = upper_x; hi_w[1] = upper_y; hi_w[2] = upper_z;
            end
        endcase
    end

    assign ap_w[0] = apex_x;
    assign ap_w[1] = apex_y;
    assign ap_w[2] = apex_z;
    assign t_s     = signed'({{(CW-31){1'b0}}, tol});

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lo_s[k] = signed'({{(CW-W){lo_w[k][W-1]}}, lo_w[k]});
            hi_s[k] = signed'({{(CW-W){hi_w[k][W-1]}}, hi_w[k]});
            ap_s[k] = signed'({{(CW-W){ap_w[k][W-1]}}, ap_w[k]});
            sel_lo[k] = opcode ? (lo_s[k] - t_s - ap_s[k]) : (lo_s[k] - ap_s[k]);
            sel_hi[k] = hi_s[k] + t_s - ap_s[k];
            mag_lo[k] = sel_lo[k][CW-1] ? MW'(-sel_lo[k]) : MW'(sel_lo[k]);
            mag_hi[k] = sel_hi[k][CW-1] ? MW'(-sel_hi[k]) : MW'(sel_hi[k]);
        end
        for (int k = 0; k < 2; k++)
        begin
            rng[k] = (lo_s[k] <= ap_s[k]) && (ap_s[k] <= hi_s[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mlo0_reg  <= mag_lo[0];
            mlo1_reg  <= mag_lo[1];
            mhi0_reg  <= mag_hi[0];
            mhi1_reg  <= mag_hi[1];
            zlo_reg   <= mag_lo[2];
            zhi_reg   <= mag_hi[2];
            flags_reg <= '{op: opcode, rng: rng};
        end
    end

    assign mlo0  = mlo0_reg;
    assign mlo1  = mlo1_reg;
    assign mhi0  = mhi0_reg;
    assign mhi1  = mhi1_reg;
    assign zlo   = zlo_reg;
    assign zhi   = zhi_reg;
    assign flags = flags_reg;

endmodule

### rtl/axis_parallel_cone_hit_test.sv
// Cone hit test for points and boxes against one cone whose axis is
// parallel to x, y or z.
// Config: write cfg_index/cfg_data with cfg_valid; cfg_ready is always
// high. Registers: 0 axis, 1..3 apex, 4 aperture, 5 cosine, 6 tolerance.
// Write them only while no word is in flight; the pipeline reads them live.
// Input: one word (opcode plus six coordinates) per cycle, taken when
// in_valid is high and in_stall low. Output: one hit word per input word,
// in order, taken when out_valid is high and out_stall low.
// Depth: 10 register stages. Throughput: one word per cycle while no
// result waits under out_stall; the chain of split 32x32 multipliers
// (three rounds of two stages each) plus prep, sum and compare stages
// sets the depth.
// Stall: the whole pipeline holds while a result waits under out_stall;
// in_stall is then high. Nothing is dropped or repeated.
// Reset: valid bits clear, registers go to axis z, apex 0, aperture 0,
// cosine one, tolerance 0.
module axis_parallel_cone_hit_test #(
    parameter int COORD_WIDTH = apcht_pkg::COORD_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [apcht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apcht_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             opcode,
    input  logic [COORD_WIDTH-1:0]           coord_x,
    input  logic [COORD_WIDTH-1:0]           coord_y,
    input  logic [COORD_WIDTH-1:0]           coord_z,
    input  logic [COORD_WIDTH-1:0]           upper_x,
    input  logic [COORD_WIDTH-1:0]           upper_y,
    input  logic [COORD_WIDTH-1:0]           upper_z,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             hit
);

    import apcht_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int MW   = ((W > 31) ? W : 31) + 1;
    localparam int SW   = 2 * MW;
    localparam int RW   = SW + 1;
    localparam int EW   = MW + APER_W;
    localparam int AW   = EW + COS_W;
    localparam int HW   = ((AW > 63) ? AW : 63) + 1;
    localparam int VBW  = RW + 2 * COS_W;
    localparam int CMPW = ((VBW + 32) > (2 * HW)) ? (VBW + 32) : (2 * HW);
    localparam int BXW  = ((2 * EW) > (RW + 32)) ? (2 * EW) : (RW + 32);
    localparam int NST  = 10;
    localparam int FW   = $bits(flag_t);

    // config registers
    logic [AXIS_W-1:0]  axis_reg;
    logic [APEX_W-1:0]  apex_reg [3];
    logic [APER_W-1:0]  aper_reg;
    logic [COS_W-1:0]   cos_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [2*COS_W-1:0] csq_reg;
    logic [W-1:0]       ap_w [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg    <= '0;
            apex_reg[0] <= '0;
            apex_reg[1] <= '0;
            apex_reg[2] <= '0;
            aper_reg    <= '0;
            cos_reg     <= COS_RESET;
            tol_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_AXIS:     axis_reg    <= cfg_data[AXIS_W-1:0];
                REG_APEX_X:   apex_reg[0] <= cfg_data[APEX_W-1:0];
                REG_APEX_Y:   apex_reg[1] <= cfg_data[APEX_W-1:0];
                REG_APEX_Z:   apex_reg[2] <= cfg_data[APEX_W-1:0];
                REG_APERTURE: aper_reg    <= cfg_data[APER_W-1:0];
                REG_COS:      cos_reg     <= cfg_data[COS_W-1:0];
                REG_TOL:      tol_reg     <= cfg_data[TOL_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        csq_reg <= cos_reg * cos_reg;
    end

    assign cfg_ready = 1'b1;

    generate
        if (W <= APEX_W)
        begin : g_apex_narrow
            for (genvar k = 0; k < 3; k++)
            begin : g_ap
                assign ap_w[k] = apex_reg[k][W-1:0];
            end
        end
        else
        begin : g_apex_wide
            for (genvar k = 0; k < 3; k++)
            begin : g_ap
                assign ap_w[k] = {{(W-APEX_W){1'b0}}, apex_reg[k]};
            end
        end
    endgenerate

    // pipeline control
    logic           en;
    logic [NST-1:0] vld_reg;

    assign en       = !vld_reg[NST-1] || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // stage 1: offsets from apex
    logic [MW-1:0] mlo0, mlo1, mhi0, mhi1, zlo, zhi;
    flag_t         flags1;

    apcht_prep #(
        .COORD_WIDTH (W),
        .MW          (MW)
    ) u_prep (
        .clk     (clk),
        .en      (en),
        .axis    (axis_reg),
        .apex_x  (ap_w[0]),
        .apex_y  (ap_w[1]),
        .apex_z  (ap_w[2]),
        .tol     (tol_reg),
        .opcode  (opcode),
        .coord_x (coord_x),
        .coord_y (coord_y),
        .coord_z (coord_z),
        .upper_x (upper_x),
        .upper_y (upper_y),
        .upper_z (upper_z),
        .mlo0    (mlo0),
        .mlo1    (mlo1),
        .mhi0    (mhi0),
        .mhi1    (mhi1),
        .zlo     (zlo),
        .zhi     (zhi),
        .flags   (flags1)
    );

    // stages 2-3: squares and expected radius
    logic [SW-1:0] sq_lo0, sq_lo1, sq_hi0, sq_hi1;
    logic [EW-1:0] e_lo3, e_hi3;
    flag_t         flags3;

    apcht_mul #(.A_W(MW), .B_W(MW)) u_sq_lo0 (.clk(clk), .en(en), .a(mlo0), .b(mlo0), .p(sq_lo0));
    apcht_mul #(.A_W(MW), .B_W(MW)) u_sq_lo1 (.clk(clk), .en(en), .a(mlo1), .b(mlo1), .p(sq_lo1));
    apcht_mul #(.A_W(MW), .B_W(MW)) u_sq_hi0 (.clk(clk), .en(en), .a(mhi0), .b(mhi0), .p(sq_hi0));
    apcht_mul #(.A_W(MW), .B_W(MW)) u_sq_hi1 (.clk(clk), .en(en), .a(mhi1), .b(mhi1), .p(sq_hi1));
    apcht_mul #(.A_W(APER_W), .B_W(MW)) u_e_lo
        (.clk(clk), .en(en), .a(aper_reg), .b(zlo), .p(e_lo3));
    apcht_mul #(.A_W(APER_W), .B_W(MW)) u_e_hi
        (.clk(clk), .en(en), .a(aper_reg), .b(zhi), .p(e_hi3));
    apcht_dly #(.WIDTH(FW), .DEPTH(2)) u_dly_f3 (.clk(clk), .en(en), .d(flags1), .q(flags3));

    // stage 4: squared radii of the four cross-axis corner pairs
    logic [RW-1:0] rsq4_reg [4];
    logic [EW-1:0] e_lo4_reg, e_hi4_reg;
    flag_t         flags4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsq4_reg[0] <= RW'(sq_lo0) + RW'(sq_lo1);
            rsq4_reg[1] <= RW'(sq_lo0) + RW'(sq_hi1);
            rsq4_reg[2] <= RW'(sq_hi0) + RW'(sq_lo1);
            rsq4_reg[3] <= RW'(sq_hi0) + RW'(sq_hi1);
            e_lo4_reg   <= e_lo3;
            e_hi4_reg   <= e_hi3;
            flags4_reg  <= flags3;
        end
    end

    // stages 5-6: scaled radius, scaled expected radius, expected squared
    logic [VBW-1:0]  vb6;
    logic [AW-1:0]   a6;
    logic [2*EW-1:0] ee_lo6, ee_hi6;
    logic [RW-1:0]   rsq6 [4];
    flag_t           flags6;

    apcht_mul #(.A_W(2*COS_W), .B_W(RW)) u_vb
        (.clk(clk), .en(en), .a(csq_reg), .b(rsq4_reg[0]), .p(vb6));
    apcht_mul #(.A_W(COS_W), .B_W(EW)) u_a
        (.clk(clk), .en(en), .a(cos_reg), .b(e_lo4_reg), .p(a6));
    apcht_mul #(.A_W(EW), .B_W(EW)) u_ee_lo
        (.clk(clk), .en(en), .a(e_lo4_reg), .b(e_lo4_reg), .p(ee_lo6));
    apcht_mul #(.A_W(EW), .B_W(EW)) u_ee_hi
        (.clk(clk), .en(en), .a(e_hi4_reg), .b(e_hi4_reg), .p(ee_hi6));
    apcht_dly #(.WIDTH(FW), .DEPTH(2)) u_dly_f6 (.clk(clk), .en(en), .d(flags4_reg), .q(flags6));

    generate
        for (genvar c = 0; c < 4; c++)
        begin : g_rsq
            apcht_dly #(.WIDTH(RW), .DEPTH(2)) u_dly_rsq
                (.clk(clk), .en(en), .d(rsq4_reg[c]), .q(rsq6[c]));
        end
    endgenerate

    // stage 7: tolerance band edges, box side test
    logic [HW-1:0] u6, hi6, lo6;
    logic          small6;
    logic [7:0]    outside6;
    logic          all_out6, none_out6, box_hit6;

    logic [HW-1:0]  hi7_reg, lo7_reg;
    logic [VBW-1:0] vb7_reg;
    logic           small7_reg, box7_reg, op7_reg;

    always_comb
    begin
        u6     = HW'({tol_reg, 32'b0});
        hi6    = HW'(a6) + u6;
        lo6    = HW'(a6) - u6;
        small6 = HW'(a6) < u6;
        for (int c = 0; c < 4; c++)
        begin
            outside6[c]     = BXW'(ee_lo6) < BXW'({rsq6[c], 32'b0});
            outside6[4 + c] = BXW'(ee_hi6) < BXW'({rsq6[c], 32'b0});
        end
        all_out6  = &outside6;
        none_out6 = ~|outside6;
        box_hit6  = !(all_out6 || none_out6)
                    || (all_out6 && (flags6.rng[0] || flags6.rng[1]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi7_reg    <= hi6;
            lo7_reg    <= lo6;
            vb7_reg    <= vb6;
            small7_reg <= small6;
            box7_reg   <= box_hit6;
            op7_reg    <= flags6.op;
        end
    end

    // stages 8-9: band edges squared
    logic [2*HW-1:0] hi2_9, lo2_9;
    logic [VBW-1:0]  vb9;
    logic [2:0]      bits9;

    apcht_mul #(.A_W(HW), .B_W(HW)) u_hi2
        (.clk(clk), .en(en), .a(hi7_reg), .b(hi7_reg), .p(hi2_9));
    apcht_mul #(.A_W(HW), .B_W(HW)) u_lo2
        (.clk(clk), .en(en), .a(lo7_reg), .b(lo7_reg), .p(lo2_9));
    apcht_dly #(.WIDTH(VBW), .DEPTH(2)) u_dly_vb (.clk(clk), .en(en), .d(vb7_reg), .q(vb9));
    apcht_dly #(.WIDTH(3), .DEPTH(2)) u_dly_b9
        (.clk(clk), .en(en), .d({small7_reg, box7_reg, op7_reg}), .q(bits9));

    // stage 10: output word
    logic [CMPW-1:0] v9;
    logic            point_hit9;
    logic            hit_reg;

    always_comb
    begin
        v9         = CMPW'({vb9, 32'b0});
        point_hit9 = (v9 < CMPW'(hi2_9)) && (bits9[2] || (v9 > CMPW'(lo2_9)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= bits9[0] ? bits9[1] : point_hit9;
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign hit       = hit_reg;

endmodule

### rtl/apcht_check.sv
module apcht_check (
    input logic clk,
    input logic rst_n,
    input logic cfg_valid,
    input logic cfg_ready,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic hit
);

    // held result word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit))
        else $error("result word changed under stall");

    // input only backs up behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // stalled input word is still offered
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("input word withdrawn under stall");

    // config port never refuses a write
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind axis_parallel_cone_hit_test apcht_check u_apcht_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit)
);

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import apcht_pkg::*;

    typedef struct {
        logic        op;
        logic [31:0] lo [3];
        logic [31:0] hi [3];
    } box_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [31:0] coord_x, coord_y, coord_z, upper_x, upper_y, upper_z;
    logic        out_valid;
    logic        out_stall;
    logic        hit;

    logic [1:0]  m_axis;
    logic [31:0] m_apex [3];
    logic [23:0] m_aper;
    logic [16:0] m_cos;
    logic [30:0] m_tol;

    box_word_t   pending_words [$];
    logic        expected_hits [$];
    int          errors;
    int          in_wait;
    int          out_wait;
    int          in_gap;
    int          out_gap;

    axis_parallel_cone_hit_test uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .upper_x(upper_x), .upper_y(upper_y), .upper_z(upper_z),
        .out_valid(out_valid), .out_stall(out_stall), .hit(hit)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [511:0] mag64(logic signed [63:0] v);
        mag64 = v < 0 ? 512'(-v) : 512'(v);
    endfunction

    function automatic logic [511:0] rad_sq(logic signed [63:0] dx, logic signed [63:0] dy);
        logic [511:0] a, b;
        a = mag64(dx);
        b = mag64(dy);
        rad_sq = (a * a + b * b) << 32;
    endfunction

    function automatic logic [511:0] exp_rad(logic signed [63:0] dz);
        exp_rad = 512'(m_aper) * mag64(dz);
    endfunction

    function automatic logic predict_hit(box_word_t w);
        int unsigned s;
        int unsigned dk;
        logic signed [63:0] lo [3], hi [3], ap [3], c [3];
        logic signed [63:0] t;
        logic [511:0] cc, v, a, u, hs, ls, e;
        logic first, o, h;
        h = 1'b0;
        first = 1'b0;
        s = (m_axis == 2'd3) ? 0 : m_axis;
        t = 64'(m_tol);
        for (int k = 0; k < 3; k++)
        begin
            dk = (k + s) % 3;
            lo[k] = 64'(signed'(w.lo[dk]));
            hi[k] = 64'(signed'(w.hi[dk]));
            ap[k] = 64'(signed'(m_apex[k]));
        end
        if (!w.op)
        begin
            cc = 512'(m_cos);
            v = cc * cc * rad_sq(lo[0] - ap[0], lo[1] - ap[1]);
            a = cc * exp_rad(lo[2] - ap[2]);
            u = 512'(m_tol) << 32;
            hs = a + u;
            if (v >= hs * hs)
                h = 1'b0;
            else if (a < u)
                h = 1'b1;
            else
            begin
                ls = a - u;
                h = v > ls * ls;
            end
        end
        else
        begin
            for (int cb = 0; cb < 8; cb++)
            begin
                if (!h)
                begin
                    for (int k = 0; k < 3; k++)
                        c[k] = cb[k] ? lo[k] - t : hi[k] + t;
                    e = exp_rad(c[2] - ap[2]);
                    o = (e * e) < rad_sq(c[0] - ap[0], c[1] - ap[1]);
                    if (cb == 0)
                        first = o;
                    else if (o != first)
                        h = 1'b1;
                end
            end
            if (!h && first)
            begin
                if (lo[0] <= ap[0] && ap[0] <= hi[0])
                    h = 1'b1;
                if (lo[1] <= ap[1] && ap[1] <= hi[1])
                    h = 1'b1;
            end
        end
        predict_hit = h;
    endfunction

    task automatic drive_front;
        in_valid <= 1'b1;
        opcode <= pending_words[0].op;
        coord_x <= pending_words[0].lo[0];
        coord_y <= pending_words[0].lo[1];
        coord_z <= pending_words[0].lo[2];
        upper_x <= pending_words[0].hi[0];
        upper_y <= pending_words[0].hi[1];
        upper_z <= pending_words[0].hi[2];
        expected_hits = {expected_hits, predict_hit(pending_words[0])};
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_wait <= 0;
        end
        else if (in_valid && !in_stall)
        begin
            void'(pending_words.pop_front());
            in_gap = $urandom_range(0, 14);
            if (in_gap == 0 && pending_words.size() > 0)
                drive_front();
            else
            begin
                in_valid <= 1'b0;
                in_wait <= (in_gap > 0) ? in_gap - 1 : 0;
            end
        end
        else if (!in_valid)
        begin
            if (in_wait > 0)
                in_wait <= in_wait - 1;
            else if (pending_words.size() > 0)
                drive_front();
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b1;
            out_wait <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_hits.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: hit %0b", hit);
                end
                else
                begin
                    if (hit !== expected_hits[0])
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %0b actual %0b",
                                expected_hits[0], hit);
                    end
                    void'(expected_hits.pop_front());
                end
                out_gap = $urandom_range(0, 14);
                out_stall <= (out_gap > 0);
                out_wait <= (out_gap > 0) ? out_gap - 1 : 0;
            end
            else if (out_wait > 0)
            begin
                out_wait <= out_wait - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_AXIS:     m_axis = val[1:0];
            REG_APEX_X:   m_apex[0] = val;
            REG_APEX_Y:   m_apex[1] = val;
            REG_APEX_Z:   m_apex[2] = val;
            REG_APERTURE: m_aper = val[23:0];
            REG_COS:      m_cos = val[16:0];
            REG_TOL:      m_tol = val[30:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (pending_words.size() > 0 || expected_hits.size() > 0 || in_valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_coord(int mode);
        case (mode)
            0: rnd_coord = $urandom;
            1: rnd_coord = 32'(signed'($urandom_range(0, 1 << 22)) - (1 << 21));
            default: rnd_coord = 32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17));
        endcase
    endfunction

    task automatic push_word(logic op, int mode);
        box_word_t w;
        logic [31:0] a, b;
        w.op = op;
        for (int k = 0; k < 3; k++)
        begin
            a = rnd_coord(mode);
            b = rnd_coord(mode);
            if ($urandom_range(0, 9) != 0 && signed'(a) > signed'(b))
            begin
                w.lo[k] = b;
                w.hi[k] = a;
            end
            else
            begin
                w.lo[k] = a;
                w.hi[k] = b;
            end
        end
        pending_words = {pending_words, w};
    endtask

    task automatic push_fixed(logic op, logic [31:0] l, logic [31:0] h);
        box_word_t w;
        w.op = op;
        for (int k = 0; k < 3; k++)
        begin
            w.lo[k] = l;
            w.hi[k] = h;
        end
        pending_words = {pending_words, w};
    endtask

    // point with x on cone axis coordinate ax, cross coordinates c0 and c1 in x-axis mode
    task automatic push_word_at(logic [31:0] ax, logic [31:0] c0, logic [31:0] c1);
        box_word_t w;
        w.op = 1'b0;
        w.lo[0] = ax;
        w.lo[1] = c0;
        w.lo[2] = c1;
        w.hi[0] = 32'h0;
        w.hi[1] = 32'h0;
        w.hi[2] = 32'h0;
        pending_words = {pending_words, w};
    endtask

    task automatic random_setting;
        write_reg(REG_AXIS, $urandom_range(0, 3));
        write_reg(REG_APEX_X, rnd_coord($urandom_range(1, 2)));
        write_reg(REG_APEX_Y, rnd_coord($urandom_range(1, 2)));
        write_reg(REG_APEX_Z, rnd_coord($urandom_range(1, 2)));
        write_reg(REG_APERTURE, $urandom_range(0, 3 << 16));
        write_reg(REG_COS, $urandom_range(30000, 65536));
        write_reg(REG_TOL, $urandom_range(0, 1 << 18));
    endtask

    initial
    begin
        errors = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        opcode = 1'b0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        upper_x = '0;
        upper_y = '0;
        upper_z = '0;
        m_axis = AXIS_Z;
        m_apex[0] = '0;
        m_apex[1] = '0;
        m_apex[2] = '0;
        m_aper = '0;
        m_cos = COS_RESET;
        m_tol = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting, extremes
        push_fixed(1'b0, 32'h0, 32'h0);
        push_fixed(1'b1, 32'h8000_0000, 32'h7fff_ffff);
        push_fixed(1'b0, 32'h7fff_ffff, 32'h8000_0000);
        push_fixed(1'b1, 32'h0001_0000, 32'hffff_0000);
        drain();

        // extreme registers
        write_reg(REG_AXIS, 32'd3);
        write_reg(REG_APEX_X, 32'h8000_0000);
        write_reg(REG_APEX_Y, 32'h7fff_ffff);
        write_reg(REG_APEX_Z, 32'hffff_ffff);
        write_reg(REG_APERTURE, 32'hff_ffff);
        write_reg(REG_COS, 32'h1_ffff);
        write_reg(REG_TOL, 32'h7fff_ffff);
        write_reg(reg_idx_t'(3'd7), 32'hffff_ffff);
        push_fixed(1'b0, 32'h7fff_ffff, 32'h0);
        push_fixed(1'b1, 32'h8000_0000, 32'h7fff_ffff);
        push_fixed(1'b1, 32'h7fff_ffff, 32'h8000_0000);
        push_fixed(1'b0, 32'h8000_0000, 32'h0);
        drain();

        // zero cosine, unit aperture, point exactly at tolerance
        write_reg(REG_AXIS, AXIS_X);
        write_reg(REG_APEX_X, 32'h0);
        write_reg(REG_APEX_Y, 32'h0);
        write_reg(REG_APEX_Z, 32'h0);
        write_reg(REG_APERTURE, 32'h1_0000);
        write_reg(REG_COS, 32'h0);
        write_reg(REG_TOL, 32'h1_0000);
        push_fixed(1'b0, 32'h3_0000, 32'h0);
        drain();
        write_reg(REG_COS, 32'h1_0000);
        push_fixed(1'b0, 32'h1_0000, 32'h0);
        push_word_at(32'h2_0000, 32'h0, 32'h1_0000);
        push_word_at(32'h2_0000, 32'h0, 32'h3_0000);
        push_fixed(1'b1, 32'h1_0000, 32'h2_0000);
        push_fixed(1'b1, 32'h2_0000, 32'h1_0000);
        push_fixed(1'b1, 32'hfff0_0000, 32'h0010_0000);
        drain();
        write_reg(REG_TOL, 32'h0);
        write_reg(REG_AXIS, AXIS_Y);
        push_fixed(1'b1, 32'h1_0000, 32'h1_0000);
        push_fixed(1'b1, 32'h5_0000, 32'h6_0000);
        drain();

        // random phases
        for (int p = 0; p < 11; p++)
        begin
            random_setting();
            for (int i = 0; i < 50; i++)
                push_word($urandom_range(0, 1), ($urandom_range(0, 9) == 0) ? 0 : 2);
            drain();
        end
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

### filelist.f
rtl/apcht_pkg.sv
rtl/apcht_dly.sv
rtl/apcht_mul.sv
rtl/apcht_prep.sv
rtl/axis_parallel_cone_hit_test.sv
rtl/apcht_check.sv
sim/tb.sv
